/* design/cir_pkg.sv */
// Shared types, widths and helper functions for the contact impulse resolver.
package cir_pkg;

  localparam int QW  = 43;  // quotient bits per division
  localparam int RW  = 17;  // divisor and remainder width
  localparam int VSH = 37;  // velocity output scaling shift
  localparam int PSH = 34;  // position output scaling shift

  typedef struct packed {
    logic [2:0][15:0] n;    // contact normal, signed Q1.14
    logic             wz;   // total inverse mass is zero
  } ctx_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] num;     // dividend bits still to come, quotient bits shifted in
  } div_t;

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(div_t s, logic [RW-1:0] w);
    logic [RW:0] r;
    div_t        o;
    r = {s.rem, s.num[QW-1]};
    if (r >= {1'b0, w}) begin
      o.rem = RW'(r - {1'b0, w});
      o.num = {s.num[QW-2:0], 1'b1};
    end else begin
      o.rem = r[RW-1:0];
      o.num = {s.num[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* design/contact_impulse_resolver.sv */
// Top level: pipelined impulse and position correction for one contact per cycle while the output is not stalled.
//
// Usage
//   Slave channel s_*: one contact per transaction. Master channel m_*: the
//   twelve velocity and position corrections for that contact, in order.
//   One contact can be taken every cycle unless the receiver stalls. The
//   pipeline holds five front stages, the 43-step restoring divider (one
//   quotient bit a stage) that splits the impulse and the push by inverse
//   mass, five back stages for the shares, products and rounding, and the
//   output register, which saturates.
//   The whole pipeline moves on one enable: it advances whenever the output
//   register is empty or is being taken. While the receiver stalls with a
//   result waiting, s_tready is low and every stage holds, so nothing is
//   lost or repeated. Bubbles travel as cleared valid bits.
//   A synchronous reset clears all valid bits; data registers are left as
//   they are. The block holds no state between contacts.
//   Body B's share is derived from body A's quotient and the remainder, so
//   a single divider per quantity serves both bodies.
module contact_impulse_resolver
  import cir_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rel_vel_x, rel_vel_y, rel_vel_z, normal_x, normal_y, normal_z, penetration,
  // inv_mass_a, inv_mass_b, bounce_a[152:144], bounce_b[161:153], zero pad
  input  logic [167:0] s_tdata,
  // has_body_b
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dvel_a_x/y/z, dvel_b_x/y/z, move_a_x/y/z, move_b_x/y/z, 16 bits each
  output logic [191:0] m_tdata
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input unpack
  logic signed [15:0] rv_in [3];
  logic signed [15:0] nv_in [3];
  logic signed [15:0] pen_in;
  logic        [15:0] ima_in, imb_in;
  logic        [8:0]  ba_in, bb_in;
  logic               hb_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv_in[i] = s_tdata[16*i +: 16];
      nv_in[i] = s_tdata[48 + 16*i +: 16];
    end
    pen_in = s_tdata[111:96];
    ima_in = s_tdata[127:112];
    imb_in = s_tdata[143:128];
    ba_in  = s_tdata[152:144];
    bb_in  = s_tdata[161:153];
    hb_in  = s_tuser[0];
  end

  // stage 1: dot product terms, restitution sum, total inverse mass
  logic                v1;
  logic signed [31:0]  pr1 [3];
  logic [10:0]         e2s1;
  logic [RW-1:0]       w1;
  logic [30:0]         pim1;
  logic [14:0]         ppos1;
  logic [15:0]         ima1;
  logic [2:0][15:0]    n1;

  // stage 2: separating velocity
  logic                v2;
  logic [31:0]         nsep2;
  logic [10:0]         e2s2;
  logic [RW-1:0]       w2;
  logic [30:0]         pim2;
  logic [14:0]         ppos2;
  logic [15:0]         ima2;
  ctx_t                ctx2;

  // stage 3: D = -sep * (1 + restitution)
  logic                v3;
  logic [QW-1:0]       d3;
  logic [RW-1:0]       w3;
  logic [30:0]         pim3;
  logic [14:0]         ppos3;
  logic [15:0]         ima3;
  ctx_t                ctx3;

  // stage 4: D * inv_mass_a as two partial products
  logic                v4;
  logic [37:0]         dh4;
  logic [36:0]         dl4;
  logic [QW-1:0]       d4;
  logic [RW-1:0]       w4;
  logic [30:0]         pim4;
  logic [14:0]         ppos4;
  ctx_t                ctx4;

  // divider stages: index 0 loads, index j+1 holds the result of step j
  logic                vd   [QW+1];
  div_t                dvv  [QW+1];
  div_t                dvp  [QW+1];
  logic [QW-1:0]       dd   [QW+1];
  logic [14:0]         dpp  [QW+1];
  logic [RW-1:0]       dw   [QW+1];
  ctx_t                dctx [QW+1];

  logic [58:0]         dm4;
  assign dm4 = {dh4, 21'b0} + {22'b0, dl4};

  // back end: shares, products, sums, magnitudes, rounding
  logic                vA, vB, vC, vD, vE;
  ctx_t                ctxA, ctxB;
  logic                wzC, wzD, wzE;
  logic [QW-1:0]       tA   [4];
  logic signed [38:0]  phB  [4][3];
  logic signed [37:0]  plB  [4][3];
  logic signed [59:0]  sC   [4][3];
  logic [58:0]         mD   [4][3];
  logic                ngD  [4][3];
  logic [24:0]         rE   [4][3];
  logic                ngE  [4][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int j = 0; j <= QW; j++) vd[j] <= 1'b0;
      vA <= 1'b0;
      vB <= 1'b0;
      vC <= 1'b0;
      vD <= 1'b0;
      vE <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vd[0] <= v4;
      for (int j = 0; j < QW; j++) vd[j+1] <= vd[j];
      vA <= vd[QW];
      vB <= vA;
      vC <= vB;
      vD <= vC;
      vE <= vD;
      m_tvalid <= vE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int i = 0; i < 3; i++) begin
        pr1[i] <= rv_in[i] * nv_in[i];
        n1[i]  <= nv_in[i];
      end
      e2s1  <= 11'd512 + {2'b0, ba_in} + {2'b0, (hb_in ? bb_in : ba_in)};
      w1    <= {1'b0, ima_in} + {1'b0, (hb_in ? imb_in : 16'd0)};
      ppos1 <= (pen_in > 16'sd0) ? pen_in[14:0] : 15'd0;
      pim1  <= (pen_in > 16'sd0) ? {16'b0, pen_in[14:0]} * {15'b0, ima_in} : 31'd0;
      ima1  <= ima_in;

      // stage 2
      begin
        logic signed [33:0] sep;
        sep = 34'(pr1[0]) + 34'(pr1[1]) + 34'(pr1[2]);
        nsep2 <= (sep < 34'sd0) ? 32'(-sep) : 32'd0;
      end
      e2s2    <= e2s1;
      w2      <= w1;
      pim2    <= pim1;
      ppos2   <= ppos1;
      ima2    <= ima1;
      ctx2.n  <= n1;
      ctx2.wz <= (w1 == '0);

      // stage 3
      d3    <= {11'b0, nsep2} * {32'b0, e2s2};
      w3    <= w2;
      pim3  <= pim2;
      ppos3 <= ppos2;
      ima3  <= ima2;
      ctx3  <= ctx2;

      // stage 4
      dh4   <= d3[42:21] * ima3;
      dl4   <= d3[20:0] * ima3;
      d4    <= d3;
      w4    <= w3;
      pim4  <= pim3;
      ppos4 <= ppos3;
      ctx4  <= ctx3;

      // divider load: top dividend bits start as the remainder
      dvv[0].rem  <= {1'b0, dm4[58:43]};
      dvv[0].num  <= dm4[42:0];
      dvp[0].rem  <= {9'b0, pim4[30:23]};
      dvp[0].num  <= {pim4[22:0], 20'b0};
      dd[0]       <= d4;
      dpp[0]      <= ppos4;
      dw[0]       <= w4;
      dctx[0]     <= ctx4;

      for (int j = 0; j < QW; j++) begin
        dvv[j+1]  <= div_step(dvv[j], dw[j]);
        dvp[j+1]  <= div_step(dvp[j], dw[j]);
        dd[j+1]   <= dd[j];
        dpp[j+1]  <= dpp[j];
        dw[j+1]   <= dw[j];
        dctx[j+1] <= dctx[j];
      end

      // stage A: body B share is the total less body A's rounded-up share
      tA[0] <= dvv[QW].num;
      tA[1] <= dd[QW] - dvv[QW].num - QW'(dvv[QW].rem != '0);
      tA[2] <= dvp[QW].num;
      tA[3] <= {8'b0, dpp[QW], 20'b0} - dvp[QW].num - QW'(dvp[QW].rem != '0);
      ctxA  <= dctx[QW];

      // stage B: share times normal, split in two partial products
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          phB[k][i] <= $signed({1'b0, tA[k][42:21]}) * $signed(ctxA.n[i]);
          plB[k][i] <= $signed({1'b0, tA[k][20:0]}) * $signed(ctxA.n[i]);
        end
      end
      ctxB <= ctxA;

      // stage C: full product
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          sC[k][i] <= $signed({phB[k][i], 21'b0}) +
                      $signed({{22{plB[k][i][37]}}, plB[k][i]});
        end
      end
      wzC <= ctxB.wz;

      // stage D: sign and magnitude
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          ngD[k][i] <= sC[k][i][59];
          mD[k][i]  <= sC[k][i][59] ? 59'(-sC[k][i]) : sC[k][i][58:0];
        end
      end
      wzD <= wzC;

      // stage E: round half away from zero; body B negated
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          logic [59:0] t;
          if (k < 2) begin
            t = {1'b0, mD[k][i]} + (60'd1 << (VSH - 1));
            rE[k][i] <= 25'(t >> VSH);
          end else begin
            t = {1'b0, mD[k][i]} + (60'd1 << (PSH - 1));
            rE[k][i] <= 25'(t >> PSH);
          end
          ngE[k][i] <= ngD[k][i] ^ k[0];
        end
      end
      wzE <= wzD;

      // output register: zero when total inverse mass is zero, else saturate
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          if (wzE) begin
            m_tdata[16*(3*k+i) +: 16] <= 16'd0;
          end else if (ngE[k][i]) begin
            m_tdata[16*(3*k+i) +: 16] <= (rE[k][i] > 25'd32768) ? 16'h8000 :
                                         16'(-rE[k][i]);
          end else begin
            m_tdata[16*(3*k+i) +: 16] <= (rE[k][i] > 25'd32767) ? 16'h7fff :
                                         rE[k][i][15:0];
          end
        end
      end
    end
  end

endmodule
